[rtl/sha1_pkg.sv]
// Shared types, constants and helper functions for the SHA-1 message hash.
package sha1_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int ROUNDS = 80;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_APPEND = 2'd1,
		OP_FINISH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] data_word;
		logic [1:0]  valid_bytes;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        init;        // load initial chaining values, clear counts
		logic        store_word;  // write wr_data at current word position
		logic        pad_fill;    // write pad word and zero the rest of the block
		logic        zero_low;    // zero words 0..13 (second padding block)
		logic        put_length;  // write the bit length into words 14 and 15
		logic        comp_start;  // load working vars from chaining values
		logic        comp_round;  // run one round
		logic        comp_end;    // chaining add
		logic        count_block; // count one message block, clear position
		logic        advance_pos; // word position plus one
		logic [31:0] wr_data;
		logic [1:0]  valid_bytes;
		logic [2:0]  out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0]  position;
		logic        last_round;
		logic [31:0] out_word;
	} dp_status_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] init_value(input logic [2:0] i);
		unique case (i)
			3'd0: init_value = H0;
			3'd1: init_value = H1;
			3'd2: init_value = H2;
			3'd3: init_value = H3;
			default: init_value = H4;
		endcase
	endfunction

endpackage

[rtl/sha1_message_hash.sv]
// Top level of the SHA-1 message hash: controller plus datapath.
//
//   channel | direction | payload
//   in      | input     | in_item_t: operation, data_word, valid_bytes
//   out     | output    | out_item_t: digest_word, word_index, last_word
//
// Start and most append transactions leave the controller idle. The sixteenth
// word of a block runs the compression, one round per cycle in the datapath.
// A finish runs one or two compressions, then presents five digest words,
// each held until taken. Reset restores the initial chaining values.
module sha1_message_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha1_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output sha1_pkg::out_item_t out_item
);
	import sha1_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	sha1_control u_control (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.out_valid, .out_ready, .out_item, .cmd, .status
	);

	sha1_datapath u_datapath (.clk, .arst_n, .cmd, .status);

endmodule

[rtl/sha1_datapath.sv]
// Datapath: chaining values, schedule, working variables and counters.
module sha1_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1_pkg::dp_cmd_t    cmd,
	output sha1_pkg::dp_status_t status
);
	import sha1_pkg::*;

	logic [31:0] chain_q [5];
	logic [31:0] sched_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [3:0]  pos_q;
	logic [6:0]  round_q;
	logic [54:0] blocks_q;

	logic [31:0] w_new, w_cur, f, k, tmp, pad_word;
	logic [63:0] bit_len;
	logic [3:0]  t4;

	assign t4 = round_q[3:0];
	assign w_new = rotl(sched_q[t4 + 4'd13] ^ sched_q[t4 + 4'd8] ^ sched_q[t4 + 4'd2]
		^ sched_q[t4], 1);
	assign w_cur = (round_q >= 7'd16) ? w_new : sched_q[t4];

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5a827999;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ed9eba1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8f1bbcdc;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hca62c1d6;
		end
	end
	assign tmp = rotl(a_q, 5) + f + e_q + k + w_cur;

	always_comb begin
		unique case (cmd.valid_bytes)
			2'd0: pad_word = {PAD_BYTE, 24'd0};
			2'd1: pad_word = {cmd.wr_data[31:24], PAD_BYTE, 16'd0};
			2'd2: pad_word = {cmd.wr_data[31:16], PAD_BYTE, 8'd0};
			default: pad_word = {cmd.wr_data[31:8], PAD_BYTE};
		endcase
	end
	assign bit_len = {blocks_q, 9'd0} + {55'd0, pos_q, cmd.valid_bytes, 3'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) chain_q[i] <= init_value(3'(i));
			pos_q    <= '0;
			round_q  <= '0;
			blocks_q <= '0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < 5; i++) chain_q[i] <= init_value(3'(i));
				pos_q    <= '0;
				blocks_q <= '0;
			end
			if (cmd.advance_pos) pos_q <= pos_q + 4'd1;
			if (cmd.count_block) begin
				pos_q    <= '0;
				blocks_q <= blocks_q + 55'd1;
			end
			if (cmd.comp_start) round_q <= '0;
			if (cmd.comp_round) round_q <= round_q + 7'd1;
			if (cmd.comp_end) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				round_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		// The length words take precedence over the zero fill of the padding block.
		for (int i = 0; i < 16; i++) begin
			if (cmd.put_length && i >= 14) begin
				sched_q[i] <= (i == 14) ? bit_len[63:32] : bit_len[31:0];
			end else if (cmd.zero_low && i < 14) begin
				sched_q[i] <= '0;
			end else if (cmd.pad_fill && 4'(i) == pos_q) begin
				sched_q[i] <= pad_word;
			end else if (cmd.pad_fill && 4'(i) > pos_q) begin
				sched_q[i] <= '0;
			end else if (cmd.store_word && 4'(i) == pos_q) begin
				sched_q[i] <= cmd.wr_data;
			end else if (cmd.comp_round && round_q >= 7'd16 && 4'(i) == t4) begin
				sched_q[i] <= w_new;
			end
		end
		if (cmd.comp_start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end
		if (cmd.comp_round) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= rotl(b_q, 30);
			b_q <= a_q;
			a_q <= tmp;
		end
	end

	assign status.position   = pos_q;
	assign status.last_round = (round_q == 7'(ROUNDS - 1));
	assign status.out_word   = chain_q[(cmd.out_sel > 3'd4) ? 3'd4 : cmd.out_sel];

endmodule

[rtl/sha1_control.sv]
// Controller: sequences word stores, padding, compressions and digest output.
module sha1_control (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha1_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha1_pkg::out_item_t   out_item,
	output sha1_pkg::dp_cmd_t     cmd,
	input  sha1_pkg::dp_status_t  status
);
	import sha1_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_ROUND, S_ADD, S_EMIT
	} state_t;

	state_t      state_q;
	logic        finish_q;   // compression belongs to a finish transaction
	logic        second_q;   // another padding block follows this compression
	logic [31:0] data_q;
	logic [1:0]  vb_q;
	logic [2:0]  idx_q;
	logic        fire;

	assign in_ready = (state_q == S_IDLE);
	assign fire = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.wr_data     = fire ? in_item.data_word : data_q;
		cmd.valid_bytes = fire ? in_item.valid_bytes : vb_q;
		cmd.out_sel     = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					unique case (op_t'(in_item.operation))
						OP_START: cmd.init = 1'b1;
						OP_APPEND: begin
							cmd.store_word  = 1'b1;
							cmd.advance_pos = (status.position != 4'd15);
						end
						OP_FINISH: begin
							cmd.pad_fill   = 1'b1;
							cmd.put_length = (status.position < 4'd14);
						end
						default: ;
					endcase
				end
			end
			S_LOAD:  cmd.comp_start = 1'b1;
			S_ROUND: cmd.comp_round = 1'b1;
			S_ADD: begin
				cmd.comp_end = 1'b1;
				if (second_q) begin
					cmd.zero_low   = 1'b1;
					cmd.put_length = 1'b1;
				end
				cmd.count_block = !finish_q;
			end
			S_EMIT: cmd.init = out_ready && (idx_q == 3'd4);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			finish_q <= 1'b0;
			second_q <= 1'b0;
			data_q   <= '0;
			vb_q     <= '0;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						data_q <= in_item.data_word;
						vb_q   <= in_item.valid_bytes;
						if (in_item.operation == OP_APPEND && status.position == 4'd15) begin
							finish_q <= 1'b0;
							second_q <= 1'b0;
							state_q  <= S_LOAD;
						end else if (in_item.operation == OP_FINISH) begin
							finish_q <= 1'b1;
							second_q <= (status.position >= 4'd14);
							state_q  <= S_LOAD;
						end
					end
				end
				S_LOAD: state_q <= S_ROUND;
				S_ROUND: if (status.last_round) state_q <= S_ADD;
				S_ADD: begin
					if (second_q) begin
						second_q <= 1'b0;
						state_q  <= S_LOAD;
					end else if (finish_q) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd4) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid            = (state_q == S_EMIT);
	assign out_item.digest_word = status.out_word;
	assign out_item.word_index  = idx_q;
	assign out_item.last_word   = (idx_q == 3'd4);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the SHA-1 message hash block.
`timescale 1ns / 100ps

module tb_top;
	import sha1_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	sha1_message_hash DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted hash state.
	logic [31:0] chain[5];
	logic [31:0] sched[16];
	logic [3:0]  word_pos;
	logic [54:0] blocks;

	out_item_t digest_q[$];
	int mismatches = 0;
	int digests_seen = 0;
	int messages = 0;
	longint cycles = 0;
	int stall_hold = 0;
	bit stall_random = 1'b1;
	int burst_left = 0;

	function automatic logic [31:0] rotl32(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic restart_chain();
		chain[0] = 32'h67452301; chain[1] = 32'hefcdab89; chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476; chain[4] = 32'hc3d2e1f0;
		word_pos = '0;
		blocks = '0;
	endtask

	task automatic compress_block();
		logic [31:0] v[5];
		logic [31:0] f, k, w, t;
		for (int i = 0; i < 5; i++) v[i] = chain[i];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				w = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15]
					^ sched[r & 15];
				sched[r & 15] = rotl32(w, 1);
			end
			w = sched[r & 15];
			if (r < 20) begin
				f = (v[1] & v[2]) | (~v[1] & v[3]); k = 32'h5a827999;
			end else if (r < 40) begin
				f = v[1] ^ v[2] ^ v[3]; k = 32'h6ed9eba1;
			end else if (r < 60) begin
				f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]); k = 32'h8f1bbcdc;
			end else begin
				f = v[1] ^ v[2] ^ v[3]; k = 32'hca62c1d6;
			end
			t = rotl32(v[0], 5) + f + v[4] + k + w;
			v[4] = v[3]; v[3] = v[2]; v[2] = rotl32(v[1], 30); v[1] = v[0]; v[0] = t;
		end
		for (int i = 0; i < 5; i++) chain[i] += v[i];
	endtask

	task automatic predict_hash(in_item_t it);
		logic [63:0] bits;
		logic [31:0] pw;
		out_item_t o;
		case (op_t'(it.operation))
			OP_START: restart_chain();
			OP_APPEND: begin
				sched[word_pos] = it.data_word;
				if (word_pos == 4'd15) begin
					compress_block();
					blocks = blocks + 1'b1;
				end
				word_pos = word_pos + 1'b1;
			end
			OP_FINISH: begin
				bits = {blocks, 9'd0} + 64'(word_pos) * 32 + 64'(it.valid_bytes) * 8;
				case (it.valid_bytes)
					2'd0: pw = {PAD_BYTE, 24'd0};
					2'd1: pw = {it.data_word[31:24], PAD_BYTE, 16'd0};
					2'd2: pw = {it.data_word[31:16], PAD_BYTE, 8'd0};
					default: pw = {it.data_word[31:8], PAD_BYTE};
				endcase
				sched[word_pos] = pw;
				for (int i = word_pos + 1; i < 16; i++) sched[i] = '0;
				if (word_pos >= 4'd14) begin
					compress_block();
					for (int i = 0; i < 14; i++) sched[i] = '0;
				end
				sched[14] = bits[63:32];
				sched[15] = bits[31:0];
				compress_block();
				for (int i = 0; i < 5; i++) begin
					o.digest_word = chain[i];
					o.word_index = 3'(i);
					o.last_word = (i == 4);
					digest_q.push_back(o);
				end
				restart_chain();
			end
			default: ;
		endcase
	endtask

	// Sends one transaction, holding valid across back-to-back items within a burst.
	task automatic send_item(logic [1:0] op, logic [31:0] data, logic [1:0] vb);
		in_item_t it;
		it.operation = op; it.data_word = data; it.valid_bytes = vb;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		predict_hash(it);
		if (op == OP_FINISH) messages++;
		if (burst_left == 0) in_valid <= 1'b0;
	endtask

	task automatic drain();
		if (burst_left != 0) begin
			burst_left = 0;
			in_valid <= 1'b0;
		end
		while (digest_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_message(int nwords, logic [1:0] vb, bit with_start);
		if (with_start) send_item(OP_START, $urandom, 2'($urandom));
		for (int i = 0; i < nwords; i++) send_item(OP_APPEND, $urandom, 2'($urandom));
		send_item(OP_FINISH, $urandom, vb);
	endtask

	task automatic test_known_vectors();
		// "abc" and the empty message.
		send_item(OP_START, 32'h0, 2'd0);
		send_item(OP_FINISH, 32'h61626300, 2'd3);
		send_item(OP_FINISH, 32'hffffffff, 2'd0);
	endtask

	task automatic test_padding_edges();
		send_item(OP_APPEND, 32'hffffffff, 2'd3); // append with no start after a finish
		send_item(OP_NONE, 32'h12345678, 2'd1);   // ignored code
		send_item(OP_FINISH, 32'h0, 2'd1);
		send_message(13, 2'd3, 1'b1);
		send_message(14, 2'd2, 1'b1);
		drain();
		send_message(15, 2'd1, 1'b0);
		send_message(16, 2'd0, 1'b1);
	endtask

	task automatic test_stalled_output();
		stall_random = 1'b0;
		stall_hold = 400;
		send_message(2, 2'd2, 1'b1);
		send_message(3, 2'd1, 1'b1);
		send_message(1, 2'd3, 1'b0);
		drain();
		stall_random = 1'b1;
	endtask

	task automatic test_random_messages();
		int r;
		while (messages < 13) begin
			r = $urandom_range(0, 9);
			if (r == 0) send_item(OP_NONE, $urandom, 2'($urandom));
			else if (r == 1) send_item(OP_APPEND, $urandom, 2'($urandom));
			else if (r < 8) send_message($urandom_range(0, 8), 2'($urandom), 1'b1);
			else send_message($urandom_range(14, 20), 2'($urandom), 1'($urandom_range(0, 1)));
		end
		drain();
	endtask

	// Receiver stall pattern, with a long hold-off when requested.
	always @(posedge clk) begin
		cycles++;
		if (stall_hold > 0) begin
			stall_hold--;
			out_ready <= 1'b0;
		end else if (stall_random)
			out_ready <= (cycles % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
		else
			out_ready <= 1'b1;
		if (cycles > 400000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			digests_seen++;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest transaction %h", out_item);
			end else begin
				want = digest_q.pop_front();
				if (out_item !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
							want.digest_word, want.word_index, want.last_word,
							out_item.digest_word, out_item.word_index, out_item.last_word);
				end
			end
		end
	end

	initial begin
		restart_chain();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_vectors();
		test_padding_edges();
		test_stalled_output();
		test_random_messages();
		$display("Hashed %0d messages, %0d digest words checked, with input gaps,",
			messages, digests_seen);
		$display("output stalls and padding at every word position class.");
		if (mismatches == 0 && digest_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
